FILE: sv/dds_pkg.sv
// dds_pkg: shared constants, types and helpers of the differential drive pid steering core
// no dependencies; compiled first
`default_nettype none

package dds_pkg;

	// sensor row and sample format
	localparam int SAMPLE_BITS_DEF = 10;
	localparam int LINE_SENSORS    = 7;
	localparam int CENTER_IDX      = (LINE_SENSORS - 1) / 2;
	localparam int WGT_W           = 4;   // lane weight, -3..3
	localparam int LSUM_W          = 6;   // sum of lane weights

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int GAIN_W     = 16;
	localparam int THR_W      = 10;
	localparam int SPEED_W    = 12;

	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KP        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KI        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KD        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BASE      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MAX       = 3'd7;

	localparam logic [GAIN_W-1:0]  RST_KP        = 16'd512;
	localparam logic [GAIN_W-1:0]  RST_KI        = 16'd0;
	localparam logic [GAIN_W-1:0]  RST_KD        = 16'd256;
	localparam logic [THR_W-1:0]   RST_THRESHOLD = 10'd446;
	localparam logic [THR_W-1:0]   RST_SETPOINT  = 10'd690;
	localparam logic [SPEED_W-1:0] RST_BASE      = 12'd1280;
	localparam logic [SPEED_W-1:0] RST_MAX       = 12'd2560;

	// pid arithmetic
	localparam int SUM_W   = 24;
	localparam int TERM_W  = 43;
	localparam int CLIP_W  = 14;          // steering term clipped to +-SPEED_LIM
	localparam int SPEED_LIM = 8191;      // beyond this every speed saturates
	localparam int SPD_X_W = CLIP_W + 1;  // base +- clipped term

	// wall mode scaling: trunc(term / 1000) by reciprocal multiply
	localparam int WALL_DIV    = 1000;
	localparam int MAG_W       = 23;
	localparam int MAG_CAP     = SPEED_LIM * WALL_DIV + WALL_DIV - 1;
	localparam int Q_W         = 13;
	localparam int RECIP_W     = 24;
	localparam int RECIP_SHIFT = 33;
	localparam logic [RECIP_W-1:0] RECIP = 24'd8589935;  // ceil(2^33 / 1000)

	typedef struct packed {
		logic               mode;
		logic [GAIN_W-1:0]  kp_gain;
		logic [GAIN_W-1:0]  ki_gain;
		logic [GAIN_W-1:0]  kd_gain;
		logic [THR_W-1:0]   line_threshold;
		logic [THR_W-1:0]   wall_setpoint;
		logic [SPEED_W-1:0] base_speed;
		logic [SPEED_W-1:0] top_speed;
	} cfg_t;

	// per-stage load enables of the datapath
	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
		logic en_s6;
	} pipe_ctl_t;

	// error width: wall error is a difference of two unsigned values
	function automatic int err_width(input int sample_bits);
		return ((sample_bits > THR_W) ? sample_bits : THR_W) + 1;
	endfunction

	function automatic logic signed [WGT_W-1:0] lane_weight(input int idx);
		return WGT_W'(idx - CENTER_IDX);
	endfunction

	function automatic logic [SPEED_W-1:0] clamp_speed(
		input logic signed [SPD_X_W-1:0] v,
		input logic [SPEED_W-1:0]        max_spd
	);
		logic signed [SPD_X_W-1:0] max_x;
		max_x = $signed({{(SPD_X_W-SPEED_W){1'b0}}, max_spd});
		if (v < 0) begin
			return '0;
		end else if (v > max_x) begin
			return max_spd;
		end else begin
			return v[SPEED_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

FILE: sv/dds_if.sv
// dds_sensor_if and dds_speed_if: valid/ready channels of the steering core
// depends on dds_pkg
`default_nettype none

interface dds_sensor_if #(
	parameter int SAMPLE_BITS = dds_pkg::SAMPLE_BITS_DEF
);
	import dds_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] ir_sample_0;
	logic [SAMPLE_BITS-1:0] ir_sample_1;
	logic [SAMPLE_BITS-1:0] ir_sample_2;
	logic [SAMPLE_BITS-1:0] ir_sample_3;
	logic [SAMPLE_BITS-1:0] ir_sample_4;
	logic [SAMPLE_BITS-1:0] ir_sample_5;
	logic [SAMPLE_BITS-1:0] ir_sample_6;
	logic [SAMPLE_BITS-1:0] sonar_left;

	modport source (
		output valid, ir_sample_0, ir_sample_1, ir_sample_2, ir_sample_3,
		       ir_sample_4, ir_sample_5, ir_sample_6, sonar_left,
		input  ready
	);
	modport sink (
		input  valid, ir_sample_0, ir_sample_1, ir_sample_2, ir_sample_3,
		       ir_sample_4, ir_sample_5, ir_sample_6, sonar_left,
		output ready
	);
endinterface

interface dds_speed_if;
	import dds_pkg::*;

	logic               valid;
	logic               ready;
	logic [SPEED_W-1:0] right_speed;
	logic [SPEED_W-1:0] left_speed;

	modport source (output valid, right_speed, left_speed, input ready);
	modport sink (input valid, right_speed, left_speed, output ready);
endinterface

`default_nettype wire

FILE: sv/dds_lane.sv
// dds_lane: one infrared sensor lane, threshold compare and weight
// depends on dds_pkg
`default_nettype none

module dds_lane #(
	parameter int                               SAMPLE_BITS = dds_pkg::SAMPLE_BITS_DEF,
	parameter logic signed [dds_pkg::WGT_W-1:0] WEIGHT      = '0
) (
	input  wire logic [SAMPLE_BITS-1:0]          sample,
	input  wire logic [dds_pkg::THR_W-1:0]       threshold,
	output logic signed [dds_pkg::WGT_W-1:0]     contrib
);
	import dds_pkg::*;

	localparam int CMP_W = err_width(SAMPLE_BITS) - 1;

	logic seen;

	// line seen when the reflection is darker than the threshold
	assign seen    = CMP_W'(sample) < CMP_W'(threshold);
	assign contrib = seen ? WEIGHT : '0;
endmodule

`default_nettype wire

FILE: sv/dds_err.sv
// dds_err: sensor lanes, merge into the steering error, saturating error sum
// depends on dds_pkg and dds_lane
`default_nettype none

module dds_err #(
	parameter int SAMPLE_BITS = dds_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  accept,
	input  wire logic                                  clear,
	input  wire logic                                  mode,
	input  wire logic [dds_pkg::THR_W-1:0]             line_threshold,
	input  wire logic [dds_pkg::THR_W-1:0]             wall_setpoint,
	input  wire logic [dds_pkg::LINE_SENSORS-1:0][SAMPLE_BITS-1:0] ir,
	input  wire logic [SAMPLE_BITS-1:0]                sonar,
	output logic signed [dds_pkg::err_width(SAMPLE_BITS)-1:0] err_s1,
	output logic signed [dds_pkg::SUM_W-1:0]                  sum_s1,
	output logic signed [dds_pkg::err_width(SAMPLE_BITS):0]   diff_s1
);
	import dds_pkg::*;

	localparam int ERR_W = err_width(SAMPLE_BITS);
	localparam int EXT_W = ERR_W - 1;

	logic signed [WGT_W-1:0]  contrib [LINE_SENSORS];
	logic signed [LSUM_W-1:0] line_err;
	logic signed [ERR_W-1:0]  wall_err;
	logic signed [ERR_W-1:0]  err;
	logic signed [SUM_W:0]    sum_ext;
	logic signed [SUM_W-1:0]  sum_sat;
	logic signed [ERR_W:0]    diff;
	logic signed [ERR_W-1:0]  last_error_q;
	logic signed [SUM_W-1:0]  error_sum_q;

	for (genvar g = 0; g < LINE_SENSORS; g++) begin : g_lane
		dds_lane #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.WEIGHT     (lane_weight(g))
		) u_lane (
			.sample   (ir[g]),
			.threshold(line_threshold),
			.contrib  (contrib[g])
		);
	end

	// merge the lane weights
	always_comb begin
		line_err = '0;
		for (int i = 0; i < LINE_SENSORS; i++) begin
			line_err = line_err + $signed({{(LSUM_W-WGT_W){contrib[i][WGT_W-1]}}, contrib[i]});
		end
	end

	assign wall_err = $signed({1'b0, EXT_W'(wall_setpoint)}) - $signed({1'b0, EXT_W'(sonar)});
	assign err = mode ? wall_err
	                  : $signed({{(ERR_W-LSUM_W){line_err[LSUM_W-1]}}, line_err});

	assign sum_ext = $signed({error_sum_q[SUM_W-1], error_sum_q})
	               + $signed({{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err});

	always_comb begin
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
			sum_sat = sum_ext[SUM_W] ? $signed({1'b1, {(SUM_W-1){1'b0}}})
			                         : $signed({1'b0, {(SUM_W-1){1'b1}}});
		end else begin
			sum_sat = sum_ext[SUM_W-1:0];
		end
	end

	assign diff = $signed({err[ERR_W-1], err}) - $signed({last_error_q[ERR_W-1], last_error_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q <= '0;
			error_sum_q  <= '0;
		end else if (clear) begin
			last_error_q <= '0;
			error_sum_q  <= '0;
		end else if (accept) begin
			last_error_q <= err;
			error_sum_q  <= sum_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_s1  <= err;
			sum_s1  <= sum_sat;
			diff_s1 <= diff;
		end
	end
endmodule

`default_nettype wire

FILE: sv/dds_pid.sv
// dds_pid: gain multiplies, term add, wall scaling and speed clamp pipeline
// depends on dds_pkg
`default_nettype none

module dds_pid #(
	parameter int SAMPLE_BITS = dds_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                        clk,
	input  wire dds_pkg::pipe_ctl_t                          ctl,
	input  wire dds_pkg::cfg_t                               cfg,
	input  wire logic signed [dds_pkg::err_width(SAMPLE_BITS)-1:0] err_s1,
	input  wire logic signed [dds_pkg::SUM_W-1:0]            sum_s1,
	input  wire logic signed [dds_pkg::err_width(SAMPLE_BITS):0]   diff_s1,
	output logic [dds_pkg::SPEED_W-1:0]                      right_speed_s6,
	output logic [dds_pkg::SPEED_W-1:0]                      left_speed_s6
);
	import dds_pkg::*;

	localparam int ERR_W = err_width(SAMPLE_BITS);
	localparam int P_W   = ERR_W + GAIN_W + 1;
	localparam int I_W   = SUM_W + GAIN_W + 1;
	localparam int D_W   = ERR_W + GAIN_W + 2;
	localparam logic signed [TERM_W-1:0] LIM_HI = TERM_W'(SPEED_LIM);
	localparam logic signed [TERM_W-1:0] LIM_LO = -LIM_HI;
	localparam logic [TERM_W-1:0]        CAP    = TERM_W'(MAG_CAP);

	logic signed [P_W-1:0]     p_s2;
	logic signed [I_W-1:0]     i_s2;
	logic signed [D_W-1:0]     d_s2;
	logic signed [TERM_W-1:0]  term_s3;
	logic [TERM_W-1:0]         abs_term;
	logic [MAG_W-1:0]          mag_s4;
	logic                      neg_s4;
	logic signed [CLIP_W-1:0]  clip_s4;
	logic [MAG_W+RECIP_W-1:0]  prod;
	logic [Q_W-1:0]            q_s5;
	logic                      neg_s5;
	logic signed [CLIP_W-1:0]  clip_s5;
	logic signed [CLIP_W-1:0]  steer;
	logic signed [SPD_X_W-1:0] base_x;
	logic signed [SPD_X_W-1:0] plus;
	logic signed [SPD_X_W-1:0] minus;

	// gain products
	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			p_s2 <= $signed({1'b0, cfg.kp_gain}) * err_s1;
			i_s2 <= $signed({1'b0, cfg.ki_gain}) * sum_s1;
			d_s2 <= $signed({1'b0, cfg.kd_gain}) * diff_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			term_s3 <= TERM_W'(p_s2) + TERM_W'(i_s2) + TERM_W'(d_s2);
		end
	end

	// clip to the range where the clamp still decides the result
	assign abs_term = term_s3[TERM_W-1] ? TERM_W'(-term_s3) : TERM_W'(term_s3);

	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			neg_s4 <= term_s3[TERM_W-1];
			mag_s4 <= (abs_term > CAP) ? MAG_W'(MAG_CAP) : abs_term[MAG_W-1:0];
			if (term_s3 > LIM_HI) begin
				clip_s4 <= LIM_HI[CLIP_W-1:0];
			end else if (term_s3 < LIM_LO) begin
				clip_s4 <= LIM_LO[CLIP_W-1:0];
			end else begin
				clip_s4 <= term_s3[CLIP_W-1:0];
			end
		end
	end

	// floor(mag / 1000), exact over the capped range
	assign prod = (MAG_W+RECIP_W)'(mag_s4) * (MAG_W+RECIP_W)'(RECIP);

	always_ff @(posedge clk) begin
		if (ctl.en_s5) begin
			q_s5    <= prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
			neg_s5  <= neg_s4;
			clip_s5 <= clip_s4;
		end
	end

	// quotient truncated toward zero in wall mode
	always_comb begin
		if (cfg.mode) begin
			steer = neg_s5 ? -$signed({1'b0, q_s5}) : $signed({1'b0, q_s5});
		end else begin
			steer = clip_s5;
		end
	end

	assign base_x = $signed({{(SPD_X_W-SPEED_W){1'b0}}, cfg.base_speed});
	assign plus   = base_x + $signed({steer[CLIP_W-1], steer});
	assign minus  = base_x - $signed({steer[CLIP_W-1], steer});

	always_ff @(posedge clk) begin
		if (ctl.en_s6) begin
			right_speed_s6 <= clamp_speed(cfg.mode ? plus : minus, cfg.top_speed);
			left_speed_s6  <= clamp_speed(cfg.mode ? minus : plus, cfg.top_speed);
		end
	end
endmodule

`default_nettype wire

FILE: sv/differential_drive_pid_steering_core.sv
// differential_drive_pid_steering_core: top level of the pid steering block
// depends on dds_pkg, dds_if, dds_err (with dds_lane) and dds_pid
`default_nettype none

// One sensor transfer in, one wheel speed transfer out. Each transfer on the
// sensor channel carries seven infrared samples and a left sonar sample; the
// block answers with right and left wheel speeds in unsigned Q4.8, clamped to
// [0, top_speed]. A new transfer is taken every clock cycle while the speed
// channel does not stall. The rate is set by the error stage: the steering
// error and the saturating error sum of one transfer are formed and stored in
// the cycle it is taken, so the next transfer sees them at once. The seven
// infrared lanes compare in parallel and a merge adds their weights (-3 .. 3,
// left to right). After that the three gain products (in one shared stage),
// the term add, the wall mode divide by 1000 (a reciprocal multiply on the
// clipped magnitude) and the clamp each own a pipeline stage. Each stage holds
// its item until the next one frees up, so a waiting result does not block
// accepting further transfers while bubbles remain in the pipe. Configuration
// registers are written through cfg_we, cfg_index and cfg_data; the user must
// do so only while the block is idle; the block itself does not enforce it.
// A mode register write also clears the stored previous error and error sum.
module differential_drive_pid_steering_core #(
	parameter int SAMPLE_BITS = dds_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [dds_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [dds_pkg::CFG_DATA_W-1:0]  cfg_data,
	dds_sensor_if.sink                           sensors,
	dds_speed_if.source                          speeds
);
	import dds_pkg::*;

	localparam int ERR_W   = err_width(SAMPLE_BITS);
	localparam int NSTAGES = 6;

	cfg_t cfg_q;

	logic [NSTAGES:1] vld_q;
	logic [NSTAGES:1] en;
	logic             accept;
	logic             clear;
	pipe_ctl_t        ctl;

	logic [LINE_SENSORS-1:0][SAMPLE_BITS-1:0] ir;

	logic signed [ERR_W-1:0] err_s1;
	logic signed [SUM_W-1:0] sum_s1;
	logic signed [ERR_W:0]   diff_s1;
	logic [SPEED_W-1:0]      right_speed_s6;
	logic [SPEED_W-1:0]      left_speed_s6;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode           <= 1'b0;
			cfg_q.kp_gain        <= RST_KP;
			cfg_q.ki_gain        <= RST_KI;
			cfg_q.kd_gain        <= RST_KD;
			cfg_q.line_threshold <= RST_THRESHOLD;
			cfg_q.wall_setpoint  <= RST_SETPOINT;
			cfg_q.base_speed     <= RST_BASE;
			cfg_q.top_speed      <= RST_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:      cfg_q.mode           <= cfg_data[0];
				REG_KP:        cfg_q.kp_gain        <= cfg_data[GAIN_W-1:0];
				REG_KI:        cfg_q.ki_gain        <= cfg_data[GAIN_W-1:0];
				REG_KD:        cfg_q.kd_gain        <= cfg_data[GAIN_W-1:0];
				REG_THRESHOLD: cfg_q.line_threshold <= cfg_data[THR_W-1:0];
				REG_SETPOINT:  cfg_q.wall_setpoint  <= cfg_data[THR_W-1:0];
				REG_BASE:      cfg_q.base_speed     <= cfg_data[SPEED_W-1:0];
				REG_MAX:       cfg_q.top_speed      <= cfg_data[SPEED_W-1:0];
				default:       cfg_q.mode           <= cfg_q.mode;
			endcase
		end
	end

	// mode change restarts the controller history
	assign clear = cfg_we && (cfg_index == REG_MODE);

	// stage advance: a stage loads when it is empty or its successor loads
	always_comb begin
		en[NSTAGES] = !vld_q[NSTAGES] || speeds.ready;
		for (int k = NSTAGES - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign sensors.ready = en[1];
	assign accept        = sensors.valid && en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= sensors.valid;
			end
			for (int k = 2; k <= NSTAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign ctl.en_s2 = en[2];
	assign ctl.en_s3 = en[3];
	assign ctl.en_s4 = en[4];
	assign ctl.en_s5 = en[5];
	assign ctl.en_s6 = en[6];

	// infrared row, leftmost sensor in lane 0
	assign ir[0] = sensors.ir_sample_0;
	assign ir[1] = sensors.ir_sample_1;
	assign ir[2] = sensors.ir_sample_2;
	assign ir[3] = sensors.ir_sample_3;
	assign ir[4] = sensors.ir_sample_4;
	assign ir[5] = sensors.ir_sample_5;
	assign ir[6] = sensors.ir_sample_6;

	// lanes, merge and stored error history
	dds_err #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_err (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.clear         (clear),
		.mode          (cfg_q.mode),
		.line_threshold(cfg_q.line_threshold),
		.wall_setpoint (cfg_q.wall_setpoint),
		.ir            (ir),
		.sonar         (sensors.sonar_left),
		.err_s1        (err_s1),
		.sum_s1        (sum_s1),
		.diff_s1       (diff_s1)
	);

	// gains, scaling and clamp
	dds_pid #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_pid (
		.clk           (clk),
		.ctl           (ctl),
		.cfg           (cfg_q),
		.err_s1        (err_s1),
		.sum_s1        (sum_s1),
		.diff_s1       (diff_s1),
		.right_speed_s6(right_speed_s6),
		.left_speed_s6 (left_speed_s6)
	);

	// output register is the last stage
	assign speeds.valid       = vld_q[NSTAGES];
	assign speeds.right_speed = right_speed_s6;
	assign speeds.left_speed  = left_speed_s6;
endmodule

`default_nettype wire

FILE: sv/dds_checker.sv
// dds_checker: port-level assertions of the steering core, bound to the top level
// depends on dds_pkg and differential_drive_pid_steering_core
`default_nettype none

module dds_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [dds_pkg::SPEED_W-1:0] right_speed,
	input wire logic [dds_pkg::SPEED_W-1:0] left_speed
);
	import dds_pkg::*;

	// a stalled result keeps its speeds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(right_speed) && $stable(left_speed))
		else $error("speed transfer changed while stalled");

	// empty output stage never back-pressures the sensor side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("sensor channel stalled with empty output stage");

	// a ready sink lets every stage advance
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("sensor channel stalled while speed sink ready");

	// nothing comes out right after reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result present right after reset");
endmodule

bind differential_drive_pid_steering_core dds_checker u_dds_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (sensors.ready),
	.out_valid  (speeds.valid),
	.out_ready  (speeds.ready),
	.right_speed(speeds.right_speed),
	.left_speed (speeds.left_speed)
);

`default_nettype wire
